// ----- src/video_test_pattern_generator_defines.svh -----
// Assertion macros shared by the checker of the test pattern generator.
// Each macro expects clk and rst_n in scope.
`ifndef VIDEO_TEST_PATTERN_GENERATOR_DEFINES_SVH
`define VIDEO_TEST_PATTERN_GENERATOR_DEFINES_SVH

// Same-cycle implication, off during reset.
`define VTPG_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, off during reset.
`define VTPG_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- src/vtpg_pkg.sv -----
// Package for the video test pattern generator: sizes, register indexes,
// pixel format codes and pattern constants. No dependencies.
`timescale 1ns / 1ps

package vtpg_pkg;

    localparam int MAX_WIDTH  = 2048;
    localparam int MAX_HEIGHT = 2048;
    localparam int MIN_SIZE   = 1;

    localparam int SIZE_W  = 12;
    localparam int COORD_W = 11;
    localparam int WORD_W  = 32;
    localparam int INDEX_W = 2;
    localparam int FRAME_W = 8;

    localparam logic [SIZE_W-1:0] WIDTH_RESET  = SIZE_W'(640);
    localparam logic [SIZE_W-1:0] HEIGHT_RESET = SIZE_W'(480);
    localparam logic [SIZE_W-1:0] WIDTH_MAX    = SIZE_W'(MAX_WIDTH);
    localparam logic [SIZE_W-1:0] HEIGHT_MAX   = SIZE_W'(MAX_HEIGHT);
    localparam logic [SIZE_W-1:0] SIZE_MIN     = SIZE_W'(MIN_SIZE);

    localparam logic [7:0] BLUE_LEVEL  = 8'd150;
    localparam logic [7:0] ALPHA_LEVEL = 8'd255;

    localparam logic [INDEX_W-1:0] REG_FRAME_WIDTH  = 2'd0;
    localparam logic [INDEX_W-1:0] REG_FRAME_HEIGHT = 2'd1;
    localparam logic [INDEX_W-1:0] REG_PIXEL_FORMAT = 2'd2;

    typedef enum logic [1:0] {
        FMT_RGB888 = 2'd0,
        FMT_RGB565 = 2'd1,
        FMT_RGB555 = 2'd2
    } pixel_format_t;

endpackage

// ----- src/video_test_pattern_generator.sv -----
// Top level of the video test pattern generator: raster counters, frame
// counter, gradient color and pixel packing. Depends on vtpg_pkg.
//
//   channel   dir  handshake           payload
//   input     in   in_valid/in_ready   restart
//   output    out  out_valid/out_ready pixel_word, pixel_x, pixel_y,
//                                      end_of_line, end_of_frame
//   config    in   cfg_write           cfg_index, cfg_data
//
// One beat in, one beat out, in the cycle after it; a new beat is taken every
// cycle while the result register is empty or being drained.
// The output register is the only stage; in_ready drops only while it is
// full and out_ready is low.
// Reset clears the counters, the frame number and the registers to their
// default size 640 x 480, rgb888.
`timescale 1ns / 1ps

module video_test_pattern_generator
    import vtpg_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_write,
    input  logic [INDEX_W-1:0]  cfg_index,
    input  logic [SIZE_W-1:0]   cfg_data,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic                restart,
    output logic                out_valid,
    input  logic                out_ready,
    output logic [WORD_W-1:0]   pixel_word,
    output logic [COORD_W-1:0]  pixel_x,
    output logic [COORD_W-1:0]  pixel_y,
    output logic                end_of_line,
    output logic                end_of_frame
);

    logic [SIZE_W-1:0]  width_reg;
    logic [SIZE_W-1:0]  height_reg;
    pixel_format_t      format_reg;

    logic [FRAME_W-1:0] frame_reg, frame_next;
    logic [COORD_W-1:0] col_reg, col_next;
    logic [COORD_W-1:0] line_reg, line_next;

    logic               out_valid_reg;
    logic [WORD_W-1:0]  word_reg, word_next;
    logic [COORD_W-1:0] x_reg, x_next;
    logic [COORD_W-1:0] y_reg, y_next;
    logic               eol_reg, eol_next;
    logic               eof_reg, eof_next;

    logic               accept;
    logic [SIZE_W-1:0]  width_eff;
    logic [SIZE_W-1:0]  height_eff;
    logic [7:0]         red;
    logic [7:0]         green;

    assign in_ready = !out_valid_reg || out_ready;
    assign accept   = in_valid && in_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= WIDTH_RESET;
            height_reg <= HEIGHT_RESET;
            format_reg <= FMT_RGB888;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                REG_FRAME_WIDTH:  width_reg  <= cfg_data;
                REG_FRAME_HEIGHT: height_reg <= cfg_data;
                REG_PIXEL_FORMAT: format_reg <= pixel_format_t'(cfg_data[1:0]);
                default:          ;
            endcase
        end
    end

    always_comb
    begin
        if (width_reg < SIZE_MIN)
            width_eff = SIZE_MIN;
        else if (width_reg > WIDTH_MAX)
            width_eff = WIDTH_MAX;
        else
            width_eff = width_reg;

        if (height_reg < SIZE_MIN)
            height_eff = SIZE_MIN;
        else if (height_reg > HEIGHT_MAX)
            height_eff = HEIGHT_MAX;
        else
            height_eff = height_reg;
    end

    always_comb
    begin
        x_next = restart ? '0 : col_reg;
        y_next = restart ? '0 : line_reg;

        if (x_next == '0 && y_next == '0)
            frame_next = frame_reg + 1'b1;
        else
            frame_next = frame_reg;

        red   = frame_next + x_next[7:0];
        green = frame_next + y_next[7:0];

        eol_next = ({1'b0, x_next} + 1'b1) >= width_eff;
        eof_next = eol_next && (({1'b0, y_next} + 1'b1) >= height_eff);

        if (eof_next)
        begin
            col_next  = '0;
            line_next = '0;
        end
        else if (eol_next)
        begin
            col_next  = '0;
            line_next = y_next + 1'b1;
        end
        else
        begin
            col_next  = x_next + 1'b1;
            line_next = y_next;
        end

        case (format_reg)
            FMT_RGB888: word_next = {ALPHA_LEVEL, BLUE_LEVEL, green, red};
            FMT_RGB565: word_next = {16'd0, BLUE_LEVEL[7:3], green[7:2], red[7:3]};
            FMT_RGB555: word_next = {17'd0, BLUE_LEVEL[7:3], green[7:3], red[7:3]};
            default:    word_next = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_reg     <= '0;
            col_reg       <= '0;
            line_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                frame_reg <= frame_next;
                col_reg   <= col_next;
                line_reg  <= line_next;
            end
            if (accept)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            word_reg <= word_next;
            x_reg    <= x_next;
            y_reg    <= y_next;
            eol_reg  <= eol_next;
            eof_reg  <= eof_next;
        end
    end

    assign out_valid    = out_valid_reg;
    assign pixel_word   = word_reg;
    assign pixel_x      = x_reg;
    assign pixel_y      = y_reg;
    assign end_of_line  = eol_reg;
    assign end_of_frame = eof_reg;

endmodule

// ----- src/vtpg_checker.sv -----
// Port-level checker for the video test pattern generator, bound to the top
// level. Depends on vtpg_pkg and video_test_pattern_generator_defines.svh.
`timescale 1ns / 1ps
`include "video_test_pattern_generator_defines.svh"

module vtpg_checker
    import vtpg_pkg::*;
(
    input logic                clk,
    input logic                rst_n,
    input logic                in_valid,
    input logic                in_ready,
    input logic                restart,
    input logic                out_valid,
    input logic                out_ready,
    input logic [WORD_W-1:0]   pixel_word,
    input logic [COORD_W-1:0]  pixel_x,
    input logic [COORD_W-1:0]  pixel_y,
    input logic                end_of_line,
    input logic                end_of_frame
);

    `VTPG_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(pixel_word) && $stable(pixel_x) && $stable(pixel_y), "stalled output beat changed")
    `VTPG_ASSERT_NOW(a_eof_has_eol, out_valid && end_of_frame, end_of_line, "end of frame without end of line")
    `VTPG_ASSERT_NEXT(a_restart_origin, in_valid && in_ready && restart, out_valid && pixel_x == '0 && pixel_y == '0, "restart beat not at origin")
    `VTPG_ASSERT_NOW(a_ready_when_empty, !out_valid, in_ready, "input stalled with empty output")

endmodule

bind video_test_pattern_generator vtpg_checker u_vtpg_checker (.*);
